>>> hw/rtl/qts_pkg.sv
package qts_pkg;

	localparam int CAPACITY_MAX = 4096;
	localparam int LIMIT_W = 13;
	localparam int ESC_W = 8;
	localparam int BYTE_W = 8;
	localparam int POS_W = 12;
	localparam int NEED_W = 16;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);
	localparam logic [ESC_W-1:0] ESC_RESET = ESC_W'(92);

	localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
	localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
	localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;

	typedef enum logic [1:0] {
		DELIM_SPACE = 2'd0,
		DELIM_DQUOTE = 2'd1,
		DELIM_SQUOTE = 2'd2
	} delim_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_UNTERM = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic {
		KIND_CHAR = 1'b0,
		KIND_END = 1'b1
	} kind_t;

	typedef enum logic {
		REG_LIMIT = 1'b0,
		REG_ESCAPE = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic kind;
		logic [BYTE_W-1:0] char_value;
		logic [POS_W-1:0] position;
		logic stored;
		logic [1:0] status;
		logic [NEED_W-1:0] needed_length;
		logic terminator_consumed;
	} result_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] buffer_limit;
		logic [ESC_W-1:0] escape_char;
	} cfg_t;

endpackage

>>> hw/rtl/qts_cfg.sv
module qts_cfg (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [qts_pkg::APB_AW-1:0] paddr,
	input logic [qts_pkg::APB_DW-1:0] pwdata,
	output logic [qts_pkg::APB_DW-1:0] prdata,
	output logic pready,
	output qts_pkg::cfg_t cfg
);
	import qts_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	logic [ESC_W-1:0] esc_q;
	reg_idx_t idx;
	logic wr_en;

	assign idx = reg_idx_t'(paddr[2]);
	assign wr_en = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			esc_q <= ESC_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_LIMIT: limit_q <= pwdata[LIMIT_W-1:0];
				REG_ESCAPE: esc_q <= pwdata[ESC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_LIMIT: prdata = APB_DW'(limit_q);
			REG_ESCAPE: prdata = APB_DW'(esc_q);
			default: prdata = '0;
		endcase
	end

	assign cfg.buffer_limit = limit_q;
	assign cfg.escape_char = esc_q;

endmodule

>>> hw/rtl/qts_scan.sv
module qts_scan (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input logic [qts_pkg::BYTE_W-1:0] byte_in,
	input qts_pkg::cfg_t cfg,
	output logic res_valid,
	output qts_pkg::result_t res
);
	import qts_pkg::*;

	logic in_token_q;
	delim_t delim_q;
	logic esc_q;
	logic [LIMIT_W-1:0] used_q;
	logic [NEED_W-1:0] need_q;
	logic full_q;

	logic in_token_d;
	delim_t delim_d;
	logic esc_d;
	logic [LIMIT_W-1:0] used_d;
	logic [NEED_W-1:0] need_d;
	logic full_d;

	logic [LIMIT_W-1:0] eff_limit;
	delim_t cur_delim;
	logic cur_esc;
	logic [LIMIT_W-1:0] cur_used;
	logic [NEED_W-1:0] cur_need;
	logic cur_full;
	logic [NEED_W-1:0] need_inc;
	logic [LIMIT_W-1:0] used_inc;
	logic [BYTE_W-1:0] delim_byte;
	logic quoted;
	logic is_end;
	logic full0;

	assign eff_limit = (cfg.buffer_limit > LIMIT_W'(CAPACITY_MAX)) ?
		LIMIT_W'(CAPACITY_MAX) : cfg.buffer_limit;
	assign full0 = (eff_limit == '0);

	always_comb begin
		if (in_token_q) begin
			cur_delim = delim_q;
			cur_esc = esc_q;
			cur_used = used_q;
			cur_need = need_q;
			cur_full = full_q;
		end else begin
			cur_delim = DELIM_SPACE;
			cur_esc = 1'b0;
			cur_used = '0;
			cur_need = '0;
			cur_full = full0;
		end
		case (cur_delim)
			DELIM_DQUOTE: delim_byte = CH_DQUOTE;
			DELIM_SQUOTE: delim_byte = CH_SQUOTE;
			default: delim_byte = CH_SPACE;
		endcase
		quoted = (cur_delim != DELIM_SPACE);
		need_inc = (cur_need == '1) ? cur_need : cur_need + NEED_W'(1);
		used_inc = cur_used + LIMIT_W'(1);
		is_end = !cur_esc && (byte_in == CH_NUL || byte_in == CH_CR ||
			byte_in == CH_LF || byte_in == delim_byte);

		in_token_d = 1'b1;
		delim_d = cur_delim;
		esc_d = 1'b0;
		used_d = cur_used;
		need_d = cur_need;
		full_d = cur_full;
		res_valid = 1'b0;
		res.kind = KIND_CHAR;
		res.char_value = byte_in;
		res.position = cur_full ? '0 : cur_used[POS_W-1:0];
		res.stored = !cur_full;
		res.status = ST_OK;
		res.needed_length = need_inc;
		res.terminator_consumed = 1'b0;

		if (!in_token_q && byte_in == CH_NUL) begin
			// empty token
			in_token_d = 1'b0;
			need_d = NEED_W'(1);
			res_valid = 1'b1;
			res.kind = KIND_END;
			res.char_value = CH_NUL;
			res.position = '0;
			res.status = full0 ? ST_OVERFLOW : ST_OK;
			res.needed_length = NEED_W'(1);
		end else if (!in_token_q && byte_in == CH_DQUOTE) begin
			delim_d = DELIM_DQUOTE;
		end else if (!in_token_q && byte_in == CH_SQUOTE) begin
			delim_d = DELIM_SQUOTE;
		end else if (is_end) begin
			in_token_d = 1'b0;
			need_d = need_inc;
			res_valid = 1'b1;
			res.kind = KIND_END;
			res.char_value = CH_NUL;
			res.terminator_consumed = quoted && (byte_in == delim_byte);
			if (quoted && byte_in != delim_byte) begin
				res.status = ST_UNTERM;
			end else if (cur_full) begin
				res.status = ST_OVERFLOW;
			end
		end else if (!cur_esc && byte_in == cfg.escape_char) begin
			esc_d = 1'b1;
		end else begin
			need_d = need_inc;
			res_valid = 1'b1;
			if (!cur_full) begin
				used_d = used_inc;
				full_d = (used_inc >= eff_limit);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_token_q <= 1'b0;
			delim_q <= DELIM_SPACE;
			esc_q <= 1'b0;
			used_q <= '0;
			need_q <= '0;
			full_q <= 1'b0;
		end else if (advance) begin
			in_token_q <= in_token_d;
			delim_q <= delim_d;
			esc_q <= esc_d;
			used_q <= used_d;
			need_q <= need_d;
			full_q <= full_d;
		end
	end

endmodule

>>> hw/rtl/quoted_token_scanner.sv
// channel    | handshake            | payload
// input      | in_valid, in_ready   | byte_value
// output     | out_valid, out_ready | kind, char_value, position, stored, status,
//            |                      | needed_length, terminator_consumed
// config     | psel, penable, pwrite| paddr, pwdata, prdata, pready
//
// one byte per cycle sustained while the result register is not stalled
// bytes go through an input register, the scan decision, then the result register
// a stalled result holds the result register and the byte waiting in the input register;
// in_ready drops while both are held and returns the cycle the result is taken
// reset clears the scan state to awaiting token start and loads register defaults
module quoted_token_scanner (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [qts_pkg::BYTE_W-1:0] byte_value,
	output logic out_valid,
	input logic out_ready,
	output logic kind,
	output logic [qts_pkg::BYTE_W-1:0] char_value,
	output logic [qts_pkg::POS_W-1:0] position,
	output logic stored,
	output logic [1:0] status,
	output logic [qts_pkg::NEED_W-1:0] needed_length,
	output logic terminator_consumed,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [qts_pkg::APB_AW-1:0] paddr,
	input logic [qts_pkg::APB_DW-1:0] pwdata,
	output logic [qts_pkg::APB_DW-1:0] prdata,
	output logic pready
);
	import qts_pkg::*;

	cfg_t cfg;
	logic valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic valid_s2;
	result_t res_s2;
	logic advance;
	logic res_valid;
	result_t res;

	qts_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	qts_scan u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.byte_in(byte_s1),
		.cfg(cfg),
		.res_valid(res_valid),
		.res(res)
	);

	assign advance = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= res_valid;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= byte_value;
		end
		if (advance && res_valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign kind = res_s2.kind;
	assign char_value = res_s2.char_value;
	assign position = res_s2.position;
	assign stored = res_s2.stored;
	assign status = res_s2.status;
	assign needed_length = res_s2.needed_length;
	assign terminator_consumed = res_s2.terminator_consumed;

endmodule

>>> sim/tb_quoted_token_scanner.sv
module tb_quoted_token_scanner;
	import qts_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_REPORTS = 10;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [BYTE_W-1:0] byte_value;
	logic out_valid;
	logic out_ready;
	logic kind;
	logic [BYTE_W-1:0] char_value;
	logic [POS_W-1:0] position;
	logic stored;
	logic [1:0] status;
	logic [NEED_W-1:0] needed_length;
	logic terminator_consumed;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	logic [BYTE_W-1:0] src_bytes[$];
	result_t want_results[$];
	result_t seen_r;
	result_t want_r;

	logic [LIMIT_W-1:0] cfg_limit;
	logic [ESC_W-1:0] cfg_escape;
	bit tok_open;
	delim_t tok_delim;
	bit esc_armed;
	logic [LIMIT_W-1:0] used_cnt;
	logic [NEED_W-1:0] need_cnt;
	bit buf_full;

	int tx_idle_pct;
	int rx_stall_pct;
	bit offer_live;
	bit hold_trigger;
	bit hold_seen;
	int hold_left;
	int mismatches;
	int unsigned cycles;

	quoted_token_scanner DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic bit ends_token(input logic [7:0] b, input logic [7:0] close_ch);
		return b == CH_NUL || b == CH_CR || b == CH_LF || b == close_ch;
	endfunction

	function automatic void scan_byte(input logic [7:0] b);
		result_t r;
		logic [LIMIT_W-1:0] lim;
		logic [7:0] close_ch;
		bit quoted;
		bit consumed;
		lim = (cfg_limit > CAPACITY_MAX) ? LIMIT_W'(CAPACITY_MAX) : cfg_limit;
		r = '0;
		if (!tok_open) begin
			esc_armed = 1'b0;
			used_cnt = '0;
			need_cnt = '0;
			buf_full = (lim == 0);
			if (b == CH_NUL) begin
				need_cnt = NEED_W'(1);
				r.kind = KIND_END;
				r.stored = !buf_full;
				r.status = buf_full ? ST_OVERFLOW : ST_OK;
				r.needed_length = need_cnt;
				want_results.push_back(r);
				return;
			end
			tok_open = 1'b1;
			if (b == CH_DQUOTE) begin
				tok_delim = DELIM_DQUOTE;
				return;
			end
			if (b == CH_SQUOTE) begin
				tok_delim = DELIM_SQUOTE;
				return;
			end
			tok_delim = DELIM_SPACE;
		end
		case (tok_delim)
			DELIM_DQUOTE: close_ch = CH_DQUOTE;
			DELIM_SQUOTE: close_ch = CH_SQUOTE;
			default: close_ch = CH_SPACE;
		endcase
		if (!esc_armed && ends_token(b, close_ch)) begin
			quoted = (tok_delim != DELIM_SPACE);
			consumed = quoted && (b == close_ch);
			if (need_cnt != '1) need_cnt++;
			r.kind = KIND_END;
			r.stored = !buf_full;
			r.position = buf_full ? '0 : used_cnt[POS_W-1:0];
			if (quoted && !consumed) r.status = ST_UNTERM;
			else if (buf_full) r.status = ST_OVERFLOW;
			else r.status = ST_OK;
			r.needed_length = need_cnt;
			r.terminator_consumed = consumed;
			tok_open = 1'b0;
			esc_armed = 1'b0;
			want_results.push_back(r);
			return;
		end
		if (!esc_armed && b == cfg_escape) begin
			esc_armed = 1'b1;
			return;
		end
		if (need_cnt != '1) need_cnt++;
		r.kind = KIND_CHAR;
		r.char_value = b;
		r.stored = !buf_full;
		r.position = buf_full ? '0 : used_cnt[POS_W-1:0];
		r.status = ST_OK;
		r.needed_length = need_cnt;
		esc_armed = 1'b0;
		if (!buf_full) begin
			used_cnt++;
			if (used_cnt >= lim) buf_full = 1'b1;
		end
		want_results.push_back(r);
	endfunction

	function automatic string fmt_result(input result_t r);
		return $sformatf("kind %0d char %h pos %0d stored %0d status %0d need %0d cons %0d",
			r.kind, r.char_value, r.position, r.stored, r.status, r.needed_length,
			r.terminator_consumed);
	endfunction

	// sender side: accept at the rising edge, offer at the falling edge
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			scan_byte(byte_value);
			void'(src_bytes.pop_front());
			offer_live = 1'b0;
		end
	end

	always @(negedge clk) begin
		if (!offer_live) begin
			if (src_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				byte_value <= src_bytes[0];
				in_valid <= 1'b1;
				offer_live = 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver side
	always @(negedge clk) begin
		if (hold_seen != hold_trigger) begin
			hold_seen = hold_trigger;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_r = {kind, char_value, position, stored, status, needed_length,
				terminator_consumed};
			if (want_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected transaction: %s", fmt_result(seen_r));
			end else begin
				want_r = want_results.pop_front();
				if (seen_r.kind !== want_r.kind || seen_r.char_value !== want_r.char_value ||
						seen_r.position !== want_r.position || seen_r.stored !== want_r.stored ||
						seen_r.status !== want_r.status ||
						seen_r.needed_length !== want_r.needed_length ||
						seen_r.terminator_consumed !== want_r.terminator_consumed) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("mismatch: expected %s", fmt_result(want_r));
						$display("          got      %s", fmt_result(seen_r));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic reg_write(input reg_idx_t idx, input int unsigned val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'({idx, 2'b00});
		pwdata <= APB_DW'(val);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_LIMIT) cfg_limit = LIMIT_W'(val);
		else cfg_escape = ESC_W'(val);
	endtask

	task automatic wait_drained();
		while (src_bytes.size() != 0 || offer_live || want_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void feed(input string s);
		for (int i = 0; i < s.len(); i++) src_bytes.push_back(s[i]);
	endfunction

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(15))
			0, 1, 2: return 8'($urandom_range(255));
			3: return CH_NUL;
			4: return CH_LF;
			5: return CH_CR;
			6: return CH_SPACE;
			7: return CH_DQUOTE;
			8: return CH_SQUOTE;
			9: return cfg_escape;
			default: return 8'($urandom_range(8'h7E, 8'h21));
		endcase
	endfunction

	function automatic void push_token();
		logic [7:0] close_ch;
		logic [7:0] c;
		int style;
		int n;
		style = $urandom_range(2);
		close_ch = (style == 1) ? CH_DQUOTE : (style == 2) ? CH_SQUOTE : CH_SPACE;
		if (style != 0) src_bytes.push_back(close_ch);
		n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
		for (int i = 0; i < n; i++) begin
			c = rand_byte();
			if (ends_token(c, close_ch) || c == cfg_escape) begin
				if (ends_token(cfg_escape, close_ch)) c = 8'h61;
				else if ($urandom_range(4) != 0) src_bytes.push_back(cfg_escape);
			end
			src_bytes.push_back(c);
		end
		if (style != 0 && $urandom_range(6) != 0) begin
			src_bytes.push_back(close_ch);
		end else begin
			case ($urandom_range(3))
				0: src_bytes.push_back(CH_NUL);
				1: src_bytes.push_back(CH_CR);
				2: src_bytes.push_back(CH_LF);
				default: src_bytes.push_back(close_ch);
			endcase
		end
	endfunction

	function automatic void fill_random(input int n);
		int added;
		int base;
		added = 0;
		while (added < n) begin
			base = src_bytes.size();
			if ($urandom_range(4) == 0) begin
				repeat ($urandom_range(6, 1)) src_bytes.push_back(rand_byte());
			end else begin
				push_token();
			end
			added += src_bytes.size() - base;
		end
	endfunction

	task automatic random_phase(input int mode, input int n);
		tx_idle_pct = (mode == 1) ? 57 : (mode == 3) ? 33 : 0;
		rx_stall_pct = (mode == 2) ? 57 : (mode == 3) ? 33 : 0;
		if (mode == 0) begin
			@(posedge clk);
			hold_trigger = !hold_trigger;
		end
		fill_random(n / 2);
		wait_drained();
		fill_random(n - n / 2);
		wait_drained();
	endtask

	initial begin
		int unsigned lim_v;
		int unsigned esc_v;
		arst_n = 1'b0;
		in_valid = 1'b0;
		byte_value = '0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		offer_live = 1'b0;
		hold_trigger = 1'b0;
		hold_seen = 1'b0;
		hold_left = 0;
		mismatches = 0;
		cycles = 0;
		cfg_limit = LIMIT_RESET;
		cfg_escape = ESC_RESET;
		tok_open = 1'b0;
		tok_delim = DELIM_SPACE;
		esc_armed = 1'b0;
		used_cnt = '0;
		need_cnt = '0;
		buf_full = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// reset settings: empty token, escaped quote, unterminated quotes, escaped nul
		src_bytes.push_back(CH_NUL);
		feed("\"ab\\\"c\"");
		feed("\"q");
		src_bytes.push_back(CH_LF);
		feed("A\\");
		src_bytes.push_back(CH_NUL);
		src_bytes.push_back(CH_CR);
		feed("'");
		src_bytes.push_back(CH_NUL);
		src_bytes.push_back(8'hFF);
		feed("xy");
		wait_drained();

		// limit drops to zero with a token still open
		reg_write(REG_LIMIT, 0);
		feed("z \"x");
		src_bytes.push_back(CH_CR);
		src_bytes.push_back(CH_NUL);
		wait_drained();

		// nul as escape never escapes
		reg_write(REG_LIMIT, 1);
		reg_write(REG_ESCAPE, 0);
		feed("ab");
		src_bytes.push_back(CH_NUL);
		wait_drained();

		// escape equal to the double quote
		reg_write(REG_ESCAPE, CH_DQUOTE);
		feed("b\"c \"a\"");
		wait_drained();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin lim_v = 256; esc_v = 92; end
				1: begin lim_v = 0; esc_v = 255; end
				2: begin lim_v = 1; esc_v = 0; end
				3: begin lim_v = 2; esc_v = CH_DQUOTE; end
				4: begin lim_v = 4096; esc_v = CH_SQUOTE; end
				5: begin lim_v = 8191; esc_v = CH_LF; end
				6: begin lim_v = 7; esc_v = CH_SPACE; end
				default: begin
					lim_v = $urandom_range(40, 3);
					esc_v = $urandom_range(255);
				end
			endcase
			reg_write(REG_LIMIT, lim_v);
			reg_write(REG_ESCAPE, esc_v);
			random_phase(p % 4, 120);
		end

		if (mismatches == 0 && want_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
